// ===== rtl/core/lahd_pkg.sv =====
// Shared types and constants for the level alarm hysteresis deadband unit.
// Holds the transaction payload structs, the configuration struct and the code values.
// No dependencies.
package lahd_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [2:0] REG_THR_HIHI    = 3'd0;
  localparam logic [2:0] REG_THR_HIGH    = 3'd1;
  localparam logic [2:0] REG_THR_LOW     = 3'd2;
  localparam logic [2:0] REG_THR_LOLO    = 3'd3;
  localparam logic [2:0] REG_LEVEL_SEVS  = 3'd4;
  localparam logic [2:0] REG_HYSTERESIS  = 3'd5;
  localparam logic [2:0] REG_VALUE_DB    = 3'd6;
  localparam logic [2:0] REG_ARCHIVE_DB  = 3'd7;

  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_UDF  = 3'd1;
  localparam logic [2:0] ST_HIHI = 3'd2;
  localparam logic [2:0] ST_LOLO = 3'd3;
  localparam logic [2:0] ST_HIGH = 3'd4;
  localparam logic [2:0] ST_LOW  = 3'd5;

  localparam logic [1:0] SEV_NONE    = 2'd0;
  localparam logic [1:0] SEV_INVALID = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               undefined;
  } in_t;

  typedef struct packed {
    logic [2:0] alarm_status;
    logic [1:0] alarm_severity;
    logic       alarm_changed;
    logic       value_event;
    logic       archive_event;
  } out_t;

  typedef struct packed {
    logic signed [15:0] thr_hihi;
    logic signed [15:0] thr_high;
    logic signed [15:0] thr_low;
    logic signed [15:0] thr_lolo;
    logic [7:0]         level_severities;
    logic [15:0]        hysteresis;
    logic signed [16:0] value_deadband;
    logic signed [16:0] archive_deadband;
  } cfg_t;

endpackage

// ===== rtl/core/lahd_regs.sv =====
// APB-style configuration register file for the alarm unit.
// Depends on lahd_pkg for the configuration struct and register indexes.
module lahd_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lahd_pkg::PADDR_W-1:0]  paddr,
  input  logic [lahd_pkg::PDATA_W-1:0]  pwdata,
  output logic [lahd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output lahd_pkg::cfg_t                cfg
);
  import lahd_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_THR_HIHI:   cfg_nxt.thr_hihi         = pwdata[15:0];
        REG_THR_HIGH:   cfg_nxt.thr_high         = pwdata[15:0];
        REG_THR_LOW:    cfg_nxt.thr_low          = pwdata[15:0];
        REG_THR_LOLO:   cfg_nxt.thr_lolo         = pwdata[15:0];
        REG_LEVEL_SEVS: cfg_nxt.level_severities = pwdata[7:0];
        REG_HYSTERESIS: cfg_nxt.hysteresis       = pwdata[15:0];
        REG_VALUE_DB:   cfg_nxt.value_deadband   = pwdata[16:0];
        REG_ARCHIVE_DB: cfg_nxt.archive_deadband = pwdata[16:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THR_HIHI:   prdata = {16'd0, cfg_r.thr_hihi};
      REG_THR_HIGH:   prdata = {16'd0, cfg_r.thr_high};
      REG_THR_LOW:    prdata = {16'd0, cfg_r.thr_low};
      REG_THR_LOLO:   prdata = {16'd0, cfg_r.thr_lolo};
      REG_LEVEL_SEVS: prdata = {24'd0, cfg_r.level_severities};
      REG_HYSTERESIS: prdata = {16'd0, cfg_r.hysteresis};
      REG_VALUE_DB:   prdata = {15'd0, cfg_r.value_deadband};
      REG_ARCHIVE_DB: prdata = {15'd0, cfg_r.archive_deadband};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/lahd_eval.sv =====
// Alarm level, hysteresis and deadband evaluation with its history registers.
// Depends on lahd_pkg for payload structs, configuration struct and codes.
module lahd_eval (
  input  logic           clk,
  input  logic           rst_n,
  input  lahd_pkg::cfg_t cfg,
  input  lahd_pkg::in_t  smp,
  input  logic           advance,
  output lahd_pkg::out_t res
);
  import lahd_pkg::*;

  logic signed [15:0] last_lvl_r,  last_lvl_nxt;
  logic signed [15:0] last_post_r, last_post_nxt;
  logic signed [15:0] last_arch_r, last_arch_nxt;
  logic [2:0]         prev_st_r;
  logic [1:0]         prev_sev_r;

  logic [1:0]         sv_hihi, sv_lolo, sv_high, sv_low;
  logic signed [17:0] v18, hyst18;
  logic signed [17:0] hihi_lim, lolo_lim, high_lim, low_lim;
  logic               hit_hihi, hit_lolo, hit_high, hit_low;
  logic [2:0]         st;
  logic [1:0]         sev;
  logic signed [16:0] pdiff, adiff;
  logic [16:0]        pabs, aabs;
  logic               vev, aev;

  assign sv_hihi = cfg.level_severities[1:0];
  assign sv_lolo = cfg.level_severities[3:2];
  assign sv_high = cfg.level_severities[5:4];
  assign sv_low  = cfg.level_severities[7:6];

  always_comb begin
    v18    = {{2{smp.sample[15]}}, smp.sample};
    hyst18 = {2'b00, cfg.hysteresis};
    hihi_lim = {{2{cfg.thr_hihi[15]}}, cfg.thr_hihi} - hyst18;
    lolo_lim = {{2{cfg.thr_lolo[15]}}, cfg.thr_lolo} + hyst18;
    high_lim = {{2{cfg.thr_high[15]}}, cfg.thr_high} - hyst18;
    low_lim  = {{2{cfg.thr_low[15]}},  cfg.thr_low}  + hyst18;

    hit_hihi = (sv_hihi != SEV_NONE) && ((smp.sample >= cfg.thr_hihi) ||
               ((last_lvl_r == cfg.thr_hihi) && (v18 >= hihi_lim)));
    hit_lolo = (sv_lolo != SEV_NONE) && ((smp.sample <= cfg.thr_lolo) ||
               ((last_lvl_r == cfg.thr_lolo) && (v18 <= lolo_lim)));
    hit_high = (sv_high != SEV_NONE) && ((smp.sample >= cfg.thr_high) ||
               ((last_lvl_r == cfg.thr_high) && (v18 >= high_lim)));
    hit_low  = (sv_low != SEV_NONE) && ((smp.sample <= cfg.thr_low) ||
               ((last_lvl_r == cfg.thr_low) && (v18 <= low_lim)));

    last_lvl_nxt = last_lvl_r;
    if (smp.undefined) begin
      st  = ST_UDF;
      sev = SEV_INVALID;
    end else if (hit_hihi) begin
      st  = ST_HIHI;
      sev = sv_hihi;
      last_lvl_nxt = cfg.thr_hihi;
    end else if (hit_lolo) begin
      st  = ST_LOLO;
      sev = sv_lolo;
      last_lvl_nxt = cfg.thr_lolo;
    end else if (hit_high) begin
      st  = ST_HIGH;
      sev = sv_high;
      last_lvl_nxt = cfg.thr_high;
    end else if (hit_low) begin
      st  = ST_LOW;
      sev = sv_low;
      last_lvl_nxt = cfg.thr_low;
    end else begin
      st  = ST_NONE;
      sev = SEV_NONE;
      last_lvl_nxt = smp.sample;
    end

    pdiff = {last_post_r[15], last_post_r} - {smp.sample[15], smp.sample};
    adiff = {last_arch_r[15], last_arch_r} - {smp.sample[15], smp.sample};
    pabs  = pdiff[16] ? 17'(-pdiff) : 17'(pdiff);
    aabs  = adiff[16] ? 17'(-adiff) : 17'(adiff);
    vev   = $signed({1'b0, pabs}) >
            $signed({cfg.value_deadband[16], cfg.value_deadband});
    aev   = $signed({1'b0, aabs}) >
            $signed({cfg.archive_deadband[16], cfg.archive_deadband});
    last_post_nxt = vev ? smp.sample : last_post_r;
    last_arch_nxt = aev ? smp.sample : last_arch_r;

    res.alarm_status   = st;
    res.alarm_severity = sev;
    res.alarm_changed  = (st != prev_st_r) || (sev != prev_sev_r);
    res.value_event    = vev;
    res.archive_event  = aev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lvl_r  <= '0;
      last_post_r <= '0;
      last_arch_r <= '0;
      prev_st_r   <= ST_NONE;
      prev_sev_r  <= SEV_NONE;
    end else if (advance) begin
      last_lvl_r  <= last_lvl_nxt;
      last_post_r <= last_post_nxt;
      last_arch_r <= last_arch_nxt;
      prev_st_r   <= st;
      prev_sev_r  <= sev;
    end
  end

endmodule

// ===== rtl/core/level_alarm_hysteresis_deadband_unit.sv =====
// Top level of the four-level alarm unit with hysteresis and deadbands.
// Instantiates lahd_regs and lahd_eval; depends on lahd_pkg.
//
// Each input transaction carries a signed 16-bit sample and an undefined flag, and yields
// exactly one result transaction with alarm status, severity, a changed flag and value and
// archive events. The unit accepts one transaction per clock cycle while the output
// side is not stalled: the sample is captured in an input register, evaluated against
// the thresholds and the alarm history in a single combinational pass, and the result
// lands in the output register while the history registers update at the same edge.
// Configuration is written through the APB-style port, one 32-bit register per word
// address, by the user only while no transaction is in flight; the unit does not check.
module level_alarm_hysteresis_deadband_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lahd_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lahd_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lahd_pkg::PADDR_W-1:0]  paddr,
  input  logic [lahd_pkg::PDATA_W-1:0]  pwdata,
  output logic [lahd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import lahd_pkg::*;

  cfg_t cfg;
  in_t  s1_data_r;
  logic s1_valid_r, s1_valid_nxt;
  out_t out_data_r;
  logic out_valid_r, out_valid_nxt;
  out_t res;
  logic out_free;
  logic advance;
  logic in_fire;

  lahd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lahd_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .smp     (s1_data_r),
    .advance (advance),
    .res     (res)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign advance   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  a_udf_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.alarm_status == ST_UDF) |->
      (out_data_r.alarm_severity == SEV_INVALID))
    else $error("undefined status without invalid severity");

  a_sev_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.alarm_status == ST_NONE) ==
                     (out_data_r.alarm_severity == SEV_NONE)))
    else $error("severity disagrees with alarm status");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while output register is empty");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_data_r))
    else $error("pending transaction lost from input register");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for level_alarm_hysteresis_deadband_unit.
// Drives sample transactions and APB register writes, predicts each alarm result
// and compares it field by field; depends on lahd_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
  import lahd_pkg::*;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] value;
    in_t         item;
    logic        has_exp;
    out_t        exp;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  cfg_t        cfg_now;
  int          alarm_level;
  int          posted_value;
  int          archived_value;
  logic [2:0]  prev_status;
  logic [1:0]  prev_severity;

  out_t        alarm_expected_q[$];
  out_t        oldest;
  int          mismatch_count;
  int          results_seen;
  int          burst_left;

  level_alarm_hysteresis_deadband_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int abs_diff(int a, int b);
    int d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  function automatic out_t alarm_predict(in_t item);
    int         v, hh, hi, lo, ll, hyst, vdb, adb;
    logic [1:0] s_hh, s_ll, s_hi, s_lo;
    out_t       r;
    v    = $signed(item.sample);
    hh   = $signed(cfg_now.thr_hihi);
    hi   = $signed(cfg_now.thr_high);
    lo   = $signed(cfg_now.thr_low);
    ll   = $signed(cfg_now.thr_lolo);
    hyst = int'(cfg_now.hysteresis);
    vdb  = $signed(cfg_now.value_deadband);
    adb  = $signed(cfg_now.archive_deadband);
    s_hh = cfg_now.level_severities[1:0];
    s_ll = cfg_now.level_severities[3:2];
    s_hi = cfg_now.level_severities[5:4];
    s_lo = cfg_now.level_severities[7:6];
    r = '0;
    if (item.undefined) begin
      r.alarm_status   = ST_UDF;
      r.alarm_severity = SEV_INVALID;
    end else if (s_hh != SEV_NONE && (v >= hh || (alarm_level == hh && v >= hh - hyst))) begin
      r.alarm_status   = ST_HIHI;
      r.alarm_severity = s_hh;
      alarm_level      = hh;
    end else if (s_ll != SEV_NONE && (v <= ll || (alarm_level == ll && v <= ll + hyst))) begin
      r.alarm_status   = ST_LOLO;
      r.alarm_severity = s_ll;
      alarm_level      = ll;
    end else if (s_hi != SEV_NONE && (v >= hi || (alarm_level == hi && v >= hi - hyst))) begin
      r.alarm_status   = ST_HIGH;
      r.alarm_severity = s_hi;
      alarm_level      = hi;
    end else if (s_lo != SEV_NONE && (v <= lo || (alarm_level == lo && v <= lo + hyst))) begin
      r.alarm_status   = ST_LOW;
      r.alarm_severity = s_lo;
      alarm_level      = lo;
    end else begin
      alarm_level = v;
    end
    r.alarm_changed = (r.alarm_status != prev_status) || (r.alarm_severity != prev_severity);
    prev_status   = r.alarm_status;
    prev_severity = r.alarm_severity;
    r.value_event = abs_diff(posted_value, v) > vdb;
    if (r.value_event) posted_value = v;
    r.archive_event = abs_diff(archived_value, v) > adb;
    if (r.archive_event) archived_value = v;
    return r;
  endfunction

  function automatic row_t row_cfg(logic [2:0] idx, int value);
    row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic row_t row_item(logic signed [15:0] sample, logic undef, logic has_exp,
                                    out_t exp);
    row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.kind           = ROW_ITEM;
    r.item.sample    = sample;
    r.item.undefined = undef;
    r.has_exp        = has_exp;
    r.exp            = exp;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_THR_HIHI:   cfg_now.thr_hihi         = value[15:0];
      REG_THR_HIGH:   cfg_now.thr_high         = value[15:0];
      REG_THR_LOW:    cfg_now.thr_low          = value[15:0];
      REG_THR_LOLO:   cfg_now.thr_lolo         = value[15:0];
      REG_LEVEL_SEVS: cfg_now.level_severities = value[7:0];
      REG_HYSTERESIS: cfg_now.hysteresis       = value[15:0];
      REG_VALUE_DB:   cfg_now.value_deadband   = value[16:0];
      REG_ARCHIVE_DB: cfg_now.archive_deadband = value[16:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (alarm_expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_sample(in_t item, logic has_exp, out_t exp);
    int   gap;
    out_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pred = alarm_predict(item);
    alarm_expected_q.push_back(has_exp ? exp : pred);
    @(negedge clk);
  endtask

  function automatic int pick_deadband();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return -1;
    if (r < 22) return -int'($urandom_range(1, 65536));
    if (r < 30) return 65535;
    return $urandom_range(0, 400);
  endfunction

  task automatic program_limits(int mode);
    int c, s, r, hyst;
    int thr[4];
    r = $urandom_range(0, 7);
    if (mode == 0) begin
      thr = '{-32768, -32768, -32768, -32768};
      hyst = 0;
    end else if (mode == 1) begin
      thr = '{32767, 32767, 32767, 32767};
      hyst = 65535;
    end else begin
      c = int'($urandom_range(0, 40000)) - 20000;
      s = $urandom_range(1, 3000);
      if (r == 0) begin
        thr = '{c, c, c, c};
      end else if (r < 3) begin
        foreach (thr[k]) thr[k] = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        thr = '{clamp16(c + 2 * s), clamp16(c + s), clamp16(c - s), clamp16(c - 2 * s)};
      end
      r = $urandom_range(0, 99);
      if (r < 15) hyst = 0;
      else if (r < 22) hyst = 65535;
      else if (r < 30) hyst = $urandom_range(0, 65535);
      else hyst = $urandom_range(0, 300);
    end
    write_reg(REG_THR_HIHI, thr[0]);
    write_reg(REG_THR_HIGH, thr[1]);
    write_reg(REG_THR_LOW, thr[2]);
    write_reg(REG_THR_LOLO, thr[3]);
    write_reg(REG_LEVEL_SEVS, (mode < 2) ? 32'hFF : $urandom_range(0, 255));
    write_reg(REG_HYSTERESIS, hyst);
    write_reg(REG_VALUE_DB, (mode == 0) ? -1 : (mode == 1) ? 65535 : pick_deadband());
    write_reg(REG_ARCHIVE_DB, (mode == 0) ? -1 : (mode == 1) ? 65535 : pick_deadband());
  endtask

  function automatic in_t random_sample();
    in_t item;
    int  r, t, span;
    r = $urandom_range(0, 99);
    span = ((cfg_now.hysteresis > 2000) ? 2000 : int'(cfg_now.hysteresis)) + 20;
    case ($urandom_range(0, 3))
      0: t = $signed(cfg_now.thr_hihi);
      1: t = $signed(cfg_now.thr_high);
      2: t = $signed(cfg_now.thr_low);
      default: t = $signed(cfg_now.thr_lolo);
    endcase
    if (r < 50) t = clamp16(t + int'($urandom_range(0, 2 * span)) - span);
    else if (r < 85) t = int'($urandom_range(0, 65535)) - 32768;
    else t = $urandom_range(0, 1) ? 32767 : -32768;
    item.sample    = 16'(t);
    item.undefined = ($urandom_range(0, 99) < 8);
    return item;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen = results_seen + 1;
      if (alarm_expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", int'(out_data), 0);
      end else begin
        oldest = alarm_expected_q.pop_front();
        if (out_data.alarm_status != oldest.alarm_status)
          report_mismatch("alarm_status", int'(out_data.alarm_status),
                          int'(oldest.alarm_status));
        if (out_data.alarm_severity != oldest.alarm_severity)
          report_mismatch("alarm_severity", int'(out_data.alarm_severity),
                          int'(oldest.alarm_severity));
        if (out_data.alarm_changed != oldest.alarm_changed)
          report_mismatch("alarm_changed", int'(out_data.alarm_changed),
                          int'(oldest.alarm_changed));
        if (out_data.value_event != oldest.value_event)
          report_mismatch("value_event", int'(out_data.value_event),
                          int'(oldest.value_event));
        if (out_data.archive_event != oldest.archive_event)
          report_mismatch("archive_event", int'(out_data.archive_event),
                          int'(oldest.archive_event));
      end
    end
  end

  initial begin
    int  pick;
    bit  long_hold_done;
    out_ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 500) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end else if (pick < 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  initial begin
    row_t directed[$];
    int   count;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_now        = '0;
    alarm_level    = 0;
    posted_value   = 0;
    archived_value = 0;
    prev_status    = ST_NONE;
    prev_severity  = SEV_NONE;
    mismatch_count = 0;
    results_seen   = 0;
    burst_left     = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With every level disabled after reset, only an undefined sample alarms.
    directed.push_back(row_item(16'sd0, 1'b0, 1'b1, {ST_NONE, SEV_NONE, 3'b000}));
    directed.push_back(row_item(16'sd32767, 1'b0, 1'b1, {ST_NONE, SEV_NONE, 3'b011}));
    directed.push_back(row_item(-16'sd32768, 1'b1, 1'b1, {ST_UDF, SEV_INVALID, 3'b111}));
    directed.push_back(row_cfg(REG_THR_HIHI, 1000));
    directed.push_back(row_cfg(REG_THR_HIGH, 500));
    directed.push_back(row_cfg(REG_THR_LOW, -500));
    directed.push_back(row_cfg(REG_THR_LOLO, -1000));
    directed.push_back(row_cfg(REG_LEVEL_SEVS, 32'h5A));
    directed.push_back(row_cfg(REG_HYSTERESIS, 50));
    directed.push_back(row_cfg(REG_VALUE_DB, -1));
    directed.push_back(row_cfg(REG_ARCHIVE_DB, 100));
    directed.push_back(row_item(16'sd1000, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd960, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd949, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd499, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd440, 1'b0, 1'b0, '0));
    directed.push_back(row_item(-16'sd1000, 1'b0, 1'b0, '0));
    directed.push_back(row_item(-16'sd960, 1'b0, 1'b0, '0));
    directed.push_back(row_item(-16'sd501, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd0, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd32767, 1'b0, 1'b0, '0));
    directed.push_back(row_item(-16'sd32768, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd123, 1'b1, 1'b0, '0));
    directed.push_back(row_cfg(REG_LEVEL_SEVS, 32'hFF));
    directed.push_back(row_cfg(REG_HYSTERESIS, 65535));
    directed.push_back(row_cfg(REG_VALUE_DB, 65535));
    directed.push_back(row_cfg(REG_ARCHIVE_DB, -5));
    directed.push_back(row_item(16'sd32767, 1'b0, 1'b0, '0));
    directed.push_back(row_item(-16'sd32768, 1'b0, 1'b0, '0));
    directed.push_back(row_cfg(REG_THR_HIHI, 0));
    directed.push_back(row_cfg(REG_THR_HIGH, 0));
    directed.push_back(row_cfg(REG_THR_LOW, 0));
    directed.push_back(row_cfg(REG_THR_LOLO, 0));
    directed.push_back(row_item(16'sd0, 1'b0, 1'b0, '0));
    directed.push_back(row_item(-16'sd1, 1'b0, 1'b0, '0));
    directed.push_back(row_item(16'sd1, 1'b0, 1'b0, '0));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (i == 0 || directed[i - 1].kind != ROW_CFG) wait_drain();
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        send_sample(directed[i].item, directed[i].has_exp, directed[i].exp);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      wait_drain();
      program_limits(phase);
      count = (phase < 2) ? 80 : 210;
      for (int n = 0; n < count; n++) begin
        if (phase == 3 && n == 100) wait_drain();
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
